[rtl/gregorian_date_stepper_assert.svh]
// Assertion macros used by the checker of the date stepper.
`ifndef GREGORIAN_DATE_STEPPER_ASSERT_SVH
`define GREGORIAN_DATE_STEPPER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define GDS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define GDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/gds_pkg.sv]
package gds_pkg;

   localparam int YEAR_W = 14;
   localparam int MON_W  = 4;
   localparam int DAY_W  = 5;
   localparam int DNUM_W = 22;
   localparam int STEP_W = 16;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;
   localparam int QY_W   = 8;
   localparam int RECIP_W = 13;
   localparam int RECIP_SHIFT = 19;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
   localparam logic [OP_W-1:0] OP_BACK    = 2'd2;
   localparam logic [OP_W-1:0] OP_DIST    = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] ST_SAT     = 2'd2;

   localparam logic [YEAR_W-1:0] MIN_YEAR   = 14'd1;
   localparam logic [YEAR_W-1:0] MAX_YEAR   = 14'd9999;
   localparam logic [YEAR_W-1:0] RESET_YEAR = 14'd2000;
   localparam logic [YEAR_W-1:0] CENTURY    = 14'd100;
   localparam logic [MON_W-1:0]  JAN        = 4'd1;
   localparam logic [MON_W-1:0]  FEB        = 4'd2;
   localparam logic [MON_W-1:0]  DEC        = 4'd12;
   localparam logic [DAY_W-1:0]  FIRST_DAY  = 5'd1;

   localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
   localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;
   localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
   localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;

   // day number of 9999-12-31, counting 0001-01-01 as 1
   localparam logic [DNUM_W-1:0] LAST_DAY_NUM = 22'd3652059;
   localparam logic [DNUM_W-1:0] DAYS_400 = 22'd146097;
   localparam logic [DNUM_W-1:0] DAYS_100 = 22'd36524;
   localparam logic [DNUM_W-1:0] DAYS_4   = 22'd1461;
   localparam logic [DNUM_W-1:0] DAYS_1   = 22'd365;
   localparam logic [DNUM_W-1:0] LEAP_LAST_REM = 22'd365;

   // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_YQ,
      CMD_YB,
      CMD_NUM,
      CMD_TARGET,
      CMD_DIV,
      CMD_FIX,
      CMD_MON,
      CMD_FINISH
   } dp_cmd_type;

   typedef enum logic [1:0] {
      PH_400,
      PH_100,
      PH_4,
      PH_1
   } div_phase_type;

   typedef struct packed {
      dp_cmd_type    cmd;
      logic          sel_arg;
      div_phase_type phase;
   } gds_cmd_type;

   typedef struct packed {
      logic ge;
      logic mon_ge;
      logic is_step;
   } gds_stat_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd2:                         len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         4'd4, 4'd6, 4'd9, 4'd11:      len = DAYS_SHORT;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:           len = DAYS_LONG;
         default:                      len = '0;
      endcase
      return len;
   endfunction

   // days before month m in a common year
   function automatic logic [8:0] cum_days(input logic [MON_W-1:0] m);
      logic [8:0] d;
      unique case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [DNUM_W-1:0] div_size(input div_phase_type ph);
      logic [DNUM_W-1:0] s;
      unique case (ph)
         PH_400: s = DAYS_400;
         PH_100: s = DAYS_100;
         PH_4:   s = DAYS_4;
         PH_1:   s = DAYS_1;
      endcase
      return s;
   endfunction

   function automatic logic [YEAR_W-1:0] div_years(input div_phase_type ph);
      logic [YEAR_W-1:0] y;
      unique case (ph)
         PH_400: y = 14'd400;
         PH_100: y = 14'd100;
         PH_4:   y = 14'd4;
         PH_1:   y = 14'd1;
      endcase
      return y;
   endfunction

endpackage

[rtl/gds_ctrl.sv]
module gds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gds_pkg::gds_cmd_type cmd,
   input  gds_pkg::gds_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_YQ_CUR,
      S_YB_CUR,
      S_NUM_CUR,
      S_YQ_ARG,
      S_YB_ARG,
      S_NUM_ARG,
      S_TARGET,
      S_DIV,
      S_FIX,
      S_MON,
      S_FINISH
   } state_type;

   state_type               state_ff;
   gds_pkg::div_phase_type  phase_ff;
   logic                    rsp_valid_ff;
   logic                    finish_go;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // output register is free, or its response leaves this cycle
   assign finish_go = rsp_ready || !rsp_valid_ff;

   always_comb begin
      cmd.cmd     = gds_pkg::CMD_NONE;
      cmd.sel_arg = 1'b0;
      cmd.phase   = phase_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid) cmd.cmd = gds_pkg::CMD_LATCH;
         S_YQ_CUR:  cmd.cmd = gds_pkg::CMD_YQ;
         S_YB_CUR:  cmd.cmd = gds_pkg::CMD_YB;
         S_NUM_CUR: cmd.cmd = gds_pkg::CMD_NUM;
         S_YQ_ARG: begin
            cmd.cmd     = gds_pkg::CMD_YQ;
            cmd.sel_arg = 1'b1;
         end
         S_YB_ARG: begin
            cmd.cmd     = gds_pkg::CMD_YB;
            cmd.sel_arg = 1'b1;
         end
         S_NUM_ARG: begin
            cmd.cmd     = gds_pkg::CMD_NUM;
            cmd.sel_arg = 1'b1;
         end
         S_TARGET:  cmd.cmd = gds_pkg::CMD_TARGET;
         S_DIV:     cmd.cmd = gds_pkg::CMD_DIV;
         S_FIX:     cmd.cmd = gds_pkg::CMD_FIX;
         S_MON:     cmd.cmd = gds_pkg::CMD_MON;
         S_FINISH:  if (finish_go) cmd.cmd = gds_pkg::CMD_FINISH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= gds_pkg::PH_400;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new response loads, or a stalled one stays
         rsp_valid_ff <= ((state_ff == S_FINISH) && finish_go) ||
                         (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            S_IDLE:    if (req_valid) state_ff <= S_YQ_CUR;
            S_YQ_CUR:  state_ff <= S_YB_CUR;
            S_YB_CUR:  state_ff <= S_NUM_CUR;
            S_NUM_CUR: state_ff <= S_YQ_ARG;
            S_YQ_ARG:  state_ff <= S_YB_ARG;
            S_YB_ARG:  state_ff <= S_NUM_ARG;
            S_NUM_ARG: state_ff <= stat.is_step ? S_TARGET : S_FINISH;
            S_TARGET: begin
               state_ff <= S_DIV;
               phase_ff <= gds_pkg::PH_400;
            end
            S_DIV: begin
               // stay while the current block size still fits
               if (!stat.ge) begin
                  unique case (phase_ff)
                     gds_pkg::PH_400: phase_ff <= gds_pkg::PH_100;
                     gds_pkg::PH_100: phase_ff <= gds_pkg::PH_4;
                     gds_pkg::PH_4:   phase_ff <= gds_pkg::PH_1;
                     gds_pkg::PH_1:   state_ff <= S_FIX;
                  endcase
               end
            end
            S_FIX:     state_ff <= S_MON;
            S_MON:     if (!stat.mon_ge) state_ff <= S_FINISH;
            S_FINISH:  if (finish_go) state_ff <= S_IDLE;
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/gds_dpath.sv]
module gds_dpath #(
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gds_pkg::gds_cmd_type         cmd,
   output gds_pkg::gds_stat_type        stat,
   input  logic [gds_pkg::OP_W-1:0]     req_opcode,
   input  logic [gds_pkg::STEP_W-1:0]   req_step_count,
   input  logic [gds_pkg::YEAR_W-1:0]   req_arg_year,
   input  logic [gds_pkg::MON_W-1:0]    req_arg_month,
   input  logic [gds_pkg::DAY_W-1:0]    req_arg_day,
   output logic [gds_pkg::YEAR_W-1:0]   rsp_out_year,
   output logic [gds_pkg::MON_W-1:0]    rsp_out_month,
   output logic [gds_pkg::DAY_W-1:0]    rsp_out_day,
   output logic [gds_pkg::DNUM_W-1:0]   rsp_distance_days,
   output logic                         rsp_stored_is_later,
   output logic [gds_pkg::STAT_W-1:0]   rsp_status
);

   localparam int YW = gds_pkg::YEAR_W;
   localparam int MW = gds_pkg::MON_W;
   localparam int DW = gds_pkg::DAY_W;
   localparam int NW = gds_pkg::DNUM_W;
   localparam int CNT_W = (COUNT_BITS < gds_pkg::STEP_W) ? COUNT_BITS : gds_pkg::STEP_W;
   localparam int SUM_W = ((CNT_W > NW) ? CNT_W : NW) + 1;
   localparam int PROD_W = YW + gds_pkg::RECIP_W;
   localparam int DBY_W = NW + 1;
   localparam int QW = gds_pkg::QY_W;

   // latched request
   logic [gds_pkg::OP_W-1:0] op_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [YW-1:0]            ay_ff;
   logic [MW-1:0]            am_ff;
   logic [DW-1:0]            ad_ff;

   // stored date
   logic [YW-1:0] cur_year_ff;
   logic [MW-1:0] cur_month_ff;
   logic [DW-1:0] cur_day_ff;

   // year unit and day numbers
   logic [QW-1:0] qy_ff;
   logic          leap_ff;
   logic [NW-1:0] dby_ff;
   logic [NW-1:0] now_ff;
   logic [NW-1:0] other_ff;
   logic          arg_ok_ff;

   // day number back to date
   logic [NW-1:0] rem_ff;
   logic          sat_ff;
   logic [YW-1:0] yacc_ff;
   logic [2:0]    q100_ff;
   logic [4:0]    q4_ff;
   logic [2:0]    q1_ff;
   logic [MW-1:0] mon_ff;

   logic [YW-1:0]     sel_y;
   logic [MW-1:0]     sel_m;
   logic [DW-1:0]     sel_d;
   logic [PROD_W-1:0] q_prod;
   logic [QW-1:0]     qy_in;
   logic [YW-1:0]     hund;
   logic [YW-1:0]     yr_rem;
   logic [QW-1:0]     qp;
   logic [YW-1:0]     p;
   logic [DBY_W-1:0]  p365;
   logic [DBY_W-1:0]  dby_full;
   logic              leap_in;
   logic [NW-1:0]     num_in;
   logic              arg_ok_in;
   logic [SUM_W-1:0]  cnt_ext;
   logic [SUM_W-1:0]  now_ext;
   logic [SUM_W-1:0]  fwd_sum;
   logic [NW-1:0]     tgt_rem;
   logic              tgt_sat;
   logic [NW-1:0]     blk_size;
   logic [DW-1:0]     mon_len;
   logic              fix_last;

   logic [YW-1:0]             fin_year;
   logic [MW-1:0]             fin_month;
   logic [DW-1:0]             fin_day;
   logic [NW-1:0]             fin_dist;
   logic                      fin_later;
   logic [gds_pkg::STAT_W-1:0] fin_status;

   assign sel_y = cmd.sel_arg ? ay_ff : cur_year_ff;
   assign sel_m = cmd.sel_arg ? am_ff : cur_month_ff;
   assign sel_d = cmd.sel_arg ? ad_ff : cur_day_ff;

   // quotient by 100 via reciprocal
   assign q_prod = PROD_W'(sel_y) * PROD_W'(gds_pkg::RECIP_100);
   assign qy_in  = q_prod[gds_pkg::RECIP_SHIFT +: QW];

   // days before year y: p*365 + p/4 - p/100 + p/400 with p = y - 1
   assign hund     = YW'(qy_ff) * gds_pkg::CENTURY;
   assign yr_rem   = sel_y - hund;
   assign qp       = (yr_rem == '0) ? (qy_ff - 1'b1) : qy_ff;
   assign p        = sel_y - 1'b1;
   assign p365     = DBY_W'(p) * DBY_W'(gds_pkg::DAYS_1);
   assign dby_full = p365 + DBY_W'(p >> 2) - DBY_W'(qp) + DBY_W'(qp >> 2);
   assign leap_in  = (sel_y[1:0] == 2'b00) && ((yr_rem != '0) || (qy_ff[1:0] == 2'b00));

   assign num_in = dby_ff + NW'(gds_pkg::cum_days(sel_m))
                 + NW'(leap_ff && (sel_m > gds_pkg::FEB)) + NW'(sel_d);

   assign arg_ok_in = (sel_y >= gds_pkg::MIN_YEAR) && (sel_y <= gds_pkg::MAX_YEAR) &&
                      (sel_m >= gds_pkg::JAN) && (sel_m <= gds_pkg::DEC) &&
                      (sel_d >= gds_pkg::FIRST_DAY) &&
                      (sel_d <= gds_pkg::month_len(sel_m, leap_ff));

   assign cnt_ext = SUM_W'(cnt_ff);
   assign now_ext = SUM_W'(now_ff);
   assign fwd_sum = now_ext + cnt_ext;

   always_comb begin
      if (op_ff == gds_pkg::OP_ADVANCE) begin
         if (fwd_sum > SUM_W'(gds_pkg::LAST_DAY_NUM)) begin
            tgt_rem = gds_pkg::LAST_DAY_NUM - 1'b1;
            tgt_sat = 1'b1;
         end else begin
            tgt_rem = NW'(fwd_sum - 1'b1);
            tgt_sat = 1'b0;
         end
      end else begin
         if (cnt_ext >= now_ext) begin
            tgt_rem = '0;
            tgt_sat = 1'b1;
         end else begin
            tgt_rem = NW'(now_ext - cnt_ext - 1'b1);
            tgt_sat = 1'b0;
         end
      end
   end

   assign blk_size = gds_pkg::div_size(cmd.phase);
   assign mon_len  = gds_pkg::month_len(mon_ff, leap_ff);
   // last day of a leap year shows up as a full fifth year or fifth century
   assign fix_last = (q1_ff == 3'd4) || (q100_ff == 3'd4);

   assign stat.ge      = (rem_ff >= blk_size);
   assign stat.mon_ge  = (mon_ff < gds_pkg::DEC) && (rem_ff >= NW'(mon_len));
   assign stat.is_step = (op_ff == gds_pkg::OP_ADVANCE) || (op_ff == gds_pkg::OP_BACK);

   always_comb begin
      fin_year   = cur_year_ff;
      fin_month  = cur_month_ff;
      fin_day    = cur_day_ff;
      fin_dist   = '0;
      fin_later  = 1'b0;
      fin_status = gds_pkg::ST_OK;
      unique case (op_ff)
         gds_pkg::OP_LOAD: begin
            if (arg_ok_ff) begin
               fin_year  = ay_ff;
               fin_month = am_ff;
               fin_day   = ad_ff;
            end else begin
               fin_status = gds_pkg::ST_INVALID;
            end
         end
         gds_pkg::OP_ADVANCE, gds_pkg::OP_BACK: begin
            fin_year   = yacc_ff;
            fin_month  = mon_ff;
            fin_day    = rem_ff[DW-1:0] + 1'b1;
            fin_status = sat_ff ? gds_pkg::ST_SAT : gds_pkg::ST_OK;
         end
         gds_pkg::OP_DIST: begin
            if (arg_ok_ff) begin
               if (now_ff > other_ff) begin
                  fin_dist  = now_ff - other_ff;
                  fin_later = 1'b1;
               end else begin
                  fin_dist  = other_ff - now_ff;
               end
            end else begin
               fin_status = gds_pkg::ST_INVALID;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_year_ff  <= gds_pkg::RESET_YEAR;
         cur_month_ff <= gds_pkg::JAN;
         cur_day_ff   <= gds_pkg::FIRST_DAY;
      end else if (cmd.cmd == gds_pkg::CMD_FINISH) begin
         cur_year_ff  <= fin_year;
         cur_month_ff <= fin_month;
         cur_day_ff   <= fin_day;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.cmd)
         gds_pkg::CMD_NONE: begin
         end
         gds_pkg::CMD_LATCH: begin
            op_ff  <= req_opcode;
            cnt_ff <= req_step_count[CNT_W-1:0];
            ay_ff  <= req_arg_year;
            am_ff  <= req_arg_month;
            ad_ff  <= req_arg_day;
         end
         gds_pkg::CMD_YQ: qy_ff <= qy_in;
         gds_pkg::CMD_YB: begin
            leap_ff <= leap_in;
            dby_ff  <= dby_full[NW-1:0];
         end
         gds_pkg::CMD_NUM: begin
            if (cmd.sel_arg) begin
               other_ff  <= num_in;
               arg_ok_ff <= arg_ok_in;
            end else begin
               now_ff    <= num_in;
            end
         end
         gds_pkg::CMD_TARGET: begin
            rem_ff  <= tgt_rem;
            sat_ff  <= tgt_sat;
            yacc_ff <= gds_pkg::MIN_YEAR;
            q100_ff <= '0;
            q4_ff   <= '0;
            q1_ff   <= '0;
            mon_ff  <= gds_pkg::JAN;
         end
         gds_pkg::CMD_DIV: begin
            if (stat.ge) begin
               rem_ff  <= rem_ff - blk_size;
               yacc_ff <= yacc_ff + gds_pkg::div_years(cmd.phase);
               unique case (cmd.phase)
                  gds_pkg::PH_400: begin
                  end
                  gds_pkg::PH_100: q100_ff <= q100_ff + 1'b1;
                  gds_pkg::PH_4:   q4_ff   <= q4_ff + 1'b1;
                  gds_pkg::PH_1:   q1_ff   <= q1_ff + 1'b1;
               endcase
            end
         end
         gds_pkg::CMD_FIX: begin
            if (fix_last) begin
               yacc_ff <= yacc_ff - 1'b1;
               rem_ff  <= gds_pkg::LEAP_LAST_REM;
               leap_ff <= 1'b1;
            end else begin
               leap_ff <= (q1_ff == 3'd3) && ((q4_ff != 5'd24) || (q100_ff == 3'd3));
            end
         end
         gds_pkg::CMD_MON: begin
            if (stat.mon_ge) begin
               rem_ff <= rem_ff - NW'(mon_len);
               mon_ff <= mon_ff + 1'b1;
            end
         end
         gds_pkg::CMD_FINISH: begin
            rsp_out_year        <= fin_year;
            rsp_out_month       <= fin_month;
            rsp_out_day         <= fin_day;
            rsp_distance_days   <= fin_dist;
            rsp_stored_is_later <= fin_later;
            rsp_status          <= fin_status;
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/gregorian_date_stepper.sv]
// Keeps one proleptic Gregorian date (reset 2000-01-01) and runs one operation per
// request: load a date, step forward or back by step_count days (clamped to
// 0001-01-01 .. 9999-12-31, status 2 when clamped), or report the day distance to a
// given date. Every request returns exactly one response. For a step the stored
// date is turned into a day number, the count is added or subtracted, and the day
// number is taken back apart by repeated subtraction of 400-year, 100-year, 4-year
// and 1-year blocks and then of month lengths. A response waiting in the output
// register holds the next one back until it is taken. A new request can be taken in
// the same cycle as the previous response becomes valid, while that response may
// still wait in the output register. Only the low COUNT_BITS bits of step_count are
// used (at most 16).
module gregorian_date_stepper #(
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gds_pkg::OP_W-1:0]     req_opcode,
   input  logic [gds_pkg::STEP_W-1:0]   req_step_count,
   input  logic [gds_pkg::YEAR_W-1:0]   req_arg_year,
   input  logic [gds_pkg::MON_W-1:0]    req_arg_month,
   input  logic [gds_pkg::DAY_W-1:0]    req_arg_day,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gds_pkg::YEAR_W-1:0]   rsp_out_year,
   output logic [gds_pkg::MON_W-1:0]    rsp_out_month,
   output logic [gds_pkg::DAY_W-1:0]    rsp_out_day,
   output logic [gds_pkg::DNUM_W-1:0]   rsp_distance_days,
   output logic                         rsp_stored_is_later,
   output logic [gds_pkg::STAT_W-1:0]   rsp_status
);

   gds_pkg::gds_cmd_type  cmd;
   gds_pkg::gds_stat_type stat;

   gds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   gds_dpath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_opcode          (req_opcode),
      .req_step_count      (req_step_count),
      .req_arg_year        (req_arg_year),
      .req_arg_month       (req_arg_month),
      .req_arg_day         (req_arg_day),
      .rsp_out_year        (rsp_out_year),
      .rsp_out_month       (rsp_out_month),
      .rsp_out_day         (rsp_out_day),
      .rsp_distance_days   (rsp_distance_days),
      .rsp_stored_is_later (rsp_stored_is_later),
      .rsp_status          (rsp_status)
   );

endmodule

[rtl/gds_checker.sv]
`include "gregorian_date_stepper_assert.svh"

module gds_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [gds_pkg::YEAR_W-1:0]   rsp_out_year,
   input logic [gds_pkg::MON_W-1:0]    rsp_out_month,
   input logic [gds_pkg::DAY_W-1:0]    rsp_out_day,
   input logic [gds_pkg::DNUM_W-1:0]   rsp_distance_days,
   input logic                         rsp_stored_is_later,
   input logic [gds_pkg::STAT_W-1:0]   rsp_status
);

   // a stalled response keeps its date and status
`GDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_year) && $stable(rsp_out_month) && $stable(rsp_out_day) && $stable(rsp_status), "response changed while stalled")

   // the stored date never leaves the calendar range
`GDS_ASSERT_SAME(a_date_range, clock, reset, rsp_valid, (rsp_out_year >= gds_pkg::MIN_YEAR) && (rsp_out_year <= gds_pkg::MAX_YEAR) && (rsp_out_month >= gds_pkg::JAN) && (rsp_out_month <= gds_pkg::DEC) && (rsp_out_day >= gds_pkg::FIRST_DAY) && (rsp_out_day <= gds_pkg::DAYS_LONG), "stored date out of range")

   // rejected or clamped requests carry no distance
`GDS_ASSERT_SAME(a_no_dist_on_error, clock, reset, rsp_valid && (rsp_status != gds_pkg::ST_OK), (rsp_distance_days == '0) && !rsp_stored_is_later, "distance reported with error status")

   // later implies a nonzero distance within the calendar span
`GDS_ASSERT_SAME(a_later_dist, clock, reset, rsp_valid && rsp_stored_is_later, (rsp_distance_days != '0) && (rsp_distance_days < gds_pkg::LAST_DAY_NUM), "later flag with bad distance")

   // one request at a time: busy right after acceptance
`GDS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")

endmodule

bind gregorian_date_stepper gds_checker u_gds_checker (.*);

[tb/date_result_checker.sv]
`timescale 1ns / 100ps

module date_result_checker
   import gds_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [STEP_W-1:0]  req_step_count,
   input  logic [YEAR_W-1:0]  req_arg_year,
   input  logic [MON_W-1:0]   req_arg_month,
   input  logic [DAY_W-1:0]   req_arg_day,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [YEAR_W-1:0]  rsp_out_year,
   input  logic [MON_W-1:0]   rsp_out_month,
   input  logic [DAY_W-1:0]   rsp_out_day,
   input  logic [DNUM_W-1:0]  rsp_distance_days,
   input  logic               rsp_stored_is_later,
   input  logic [STAT_W-1:0]  rsp_status,
   output int                 error_count,
   output int                 outstanding,
   output int                 responses_checked,
   output int                 saturations,
   output int                 rejections
);

   typedef struct {
      logic [YEAR_W-1:0] year;
      logic [MON_W-1:0]  month;
      logic [DAY_W-1:0]  day;
      logic [DNUM_W-1:0] distance;
      logic              later;
      logic [STAT_W-1:0] status;
   } calendar_result_type;

   calendar_result_type expected_results[$];

   // shadow copy of the stored date
   int unsigned cal_year  = RESET_YEAR;
   int unsigned cal_month = JAN;
   int unsigned cal_day   = FIRST_DAY;

   initial begin
      error_count       = 0;
      outstanding       = 0;
      responses_checked = 0;
      saturations       = 0;
      rejections        = 0;
   end

   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && !((y % CENTURY == 0) && (y % 400 != 0));
   endfunction

   function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m);
      int unsigned len;
      case (m)
         2:               len = leap_year(y) ? DAYS_FEB_LEAP : DAYS_FEB;
         4, 6, 9, 11:     len = DAYS_SHORT;
         1, 3, 5, 7, 8,
         10, 12:          len = DAYS_LONG;
         default:         len = 0;
      endcase
      return len;
   endfunction

   function automatic bit date_valid(input int unsigned y, m, d);
      return y >= MIN_YEAR && y <= MAX_YEAR && m >= JAN && m <= DEC &&
             d >= 1 && d <= days_of_month(y, m);
   endfunction

   function automatic int unsigned days_prior(input int unsigned y);
      int unsigned p;
      p = y - 1;
      return p * 365 + p / 4 - p / 100 + p / 400;
   endfunction

   // 0001-01-01 is day 1
   function automatic int unsigned ordinal_of(input int unsigned y, m, d);
      int unsigned n;
      n = days_prior(y);
      for (int unsigned k = 1; k < m; k++) n += days_of_month(y, k);
      return n + d;
   endfunction

   task automatic move_to_ordinal(input int unsigned n);
      int unsigned rem;
      int unsigned y;
      int unsigned m;
      rem = n - 1;
      y = rem / 366 + 1;
      m = 1;
      while (y < MAX_YEAR && days_prior(y + 1) <= rem) y++;
      rem -= days_prior(y);
      while (m < 12 && rem >= days_of_month(y, m)) begin
         rem -= days_of_month(y, m);
         m++;
      end
      cal_year  = y;
      cal_month = m;
      cal_day   = rem + 1;
   endtask

   task automatic predict_calendar(input logic [OP_W-1:0] op, input int unsigned cnt_raw,
                                   input int unsigned ay, am, ad,
                                   output calendar_result_type res);
      int unsigned now;
      int unsigned cnt;
      int unsigned target;
      int unsigned other;
      now = ordinal_of(cal_year, cal_month, cal_day);
      cnt = cnt_raw & ((32'd1 << COUNT_BITS) - 1);
      res.distance = '0;
      res.later    = 1'b0;
      res.status   = ST_OK;
      case (op)
         OP_LOAD: begin
            if (date_valid(ay, am, ad)) begin
               cal_year  = ay;
               cal_month = am;
               cal_day   = ad;
            end else begin
               res.status = ST_INVALID;
            end
         end
         OP_ADVANCE: begin
            target = now + cnt;
            if (target > LAST_DAY_NUM) begin
               target     = LAST_DAY_NUM;
               res.status = ST_SAT;
            end
            move_to_ordinal(target);
         end
         OP_BACK: begin
            // landing exactly on day 1 is not a clamp
            if (cnt >= now) begin
               target     = 1;
               res.status = ST_SAT;
            end else begin
               target = now - cnt;
            end
            move_to_ordinal(target);
         end
         default: begin
            if (date_valid(ay, am, ad)) begin
               other = ordinal_of(ay, am, ad);
               if (now > other) begin
                  res.distance = DNUM_W'(now - other);
                  res.later    = 1'b1;
               end else begin
                  res.distance = DNUM_W'(other - now);
               end
            end else begin
               res.status = ST_INVALID;
            end
         end
      endcase
      res.year  = YEAR_W'(cal_year);
      res.month = MON_W'(cal_month);
      res.day   = DAY_W'(cal_day);
   endtask

   task automatic check_field(input string field, input int unsigned want, got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      calendar_result_type want;
      calendar_result_type fresh;
      if (reset) begin
         cal_year  = RESET_YEAR;
         cal_month = JAN;
         cal_day   = FIRST_DAY;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("year", want.year, rsp_out_year);
               check_field("month", want.month, rsp_out_month);
               check_field("day", want.day, rsp_out_day);
               check_field("distance_days", want.distance, rsp_distance_days);
               check_field("stored_is_later", want.later, rsp_stored_is_later);
               check_field("status", want.status, rsp_status);
               if (want.status == ST_SAT) saturations++;
               if (want.status == ST_INVALID) rejections++;
               responses_checked++;
            end
         end
         if (req_valid && req_ready) begin
            predict_calendar(req_opcode, req_step_count, req_arg_year, req_arg_month,
                             req_arg_day, fresh);
            expected_results.push_back(fresh);
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import gds_pkg::*;

   localparam int STEP_BITS      = 16;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 120;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_opcode = OP_LOAD;
   logic [STEP_W-1:0]   req_step_count = '0;
   logic [YEAR_W-1:0]   req_arg_year = RESET_YEAR;
   logic [MON_W-1:0]    req_arg_month = JAN;
   logic [DAY_W-1:0]    req_arg_day = FIRST_DAY;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [YEAR_W-1:0]   rsp_out_year;
   logic [MON_W-1:0]    rsp_out_month;
   logic [DAY_W-1:0]    rsp_out_day;
   logic [DNUM_W-1:0]   rsp_distance_days;
   logic                rsp_stored_is_later;
   logic [STAT_W-1:0]   rsp_status;

   int error_count;
   int outstanding;
   int responses_checked;
   int saturations;
   int rejections;
   int op_tally[4] = '{0, 0, 0, 0};
   int quiet_cycles = 0;
   int stall_mode = 0;
   int stall_timer = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gregorian_date_stepper #(
      .COUNT_BITS(STEP_BITS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_step_count      (req_step_count),
      .req_arg_year        (req_arg_year),
      .req_arg_month       (req_arg_month),
      .req_arg_day         (req_arg_day),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_year        (rsp_out_year),
      .rsp_out_month       (rsp_out_month),
      .rsp_out_day         (rsp_out_day),
      .rsp_distance_days   (rsp_distance_days),
      .rsp_stored_is_later (rsp_stored_is_later),
      .rsp_status          (rsp_status)
   );

   date_result_checker #(
      .COUNT_BITS(STEP_BITS)
   ) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_step_count      (req_step_count),
      .req_arg_year        (req_arg_year),
      .req_arg_month       (req_arg_month),
      .req_arg_day         (req_arg_day),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_year        (rsp_out_year),
      .rsp_out_month       (rsp_out_month),
      .rsp_out_day         (rsp_out_day),
      .rsp_distance_days   (rsp_distance_days),
      .rsp_stored_is_later (rsp_stored_is_later),
      .rsp_status          (rsp_status),
      .error_count         (error_count),
      .outstanding         (outstanding),
      .responses_checked   (responses_checked),
      .saturations         (saturations),
      .rejections          (rejections)
   );

   // receiver: stall style is picked anew each time its timer runs out
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 3);
         stall_timer <= $urandom_range(50, 400);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= (stall_timer % 5 != 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL gregorian_date_stepper");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // holds the request until it is taken
   task automatic send_request(input logic [OP_W-1:0] op, input logic [STEP_W-1:0] cnt,
                               input logic [YEAR_W-1:0] y, input logic [MON_W-1:0] m,
                               input logic [DAY_W-1:0] d);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_step_count <= cnt;
      req_arg_year   <= y;
      req_arg_month  <= m;
      req_arg_day    <= d;
      op_tally[op]++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_random_request();
      logic [OP_W-1:0]   op;
      logic [STEP_W-1:0] cnt;
      logic [YEAR_W-1:0] y;
      logic [MON_W-1:0]  m;
      logic [DAY_W-1:0]  d;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)      op = OP_LOAD;
      else if (pick < 55) op = OP_ADVANCE;
      else if (pick < 85) op = OP_BACK;
      else                op = OP_DIST;
      case ($urandom_range(0, 9))
         0:       cnt = '0;
         1:       cnt = STEP_W'($urandom);
         2:       cnt = '1;
         default: cnt = STEP_W'($urandom_range(1, 800));
      endcase
      case ($urandom_range(0, 9))
         0:       y = YEAR_W'($urandom_range(1, 3));
         1:       y = YEAR_W'($urandom_range(9997, 9999));
         2:       y = YEAR_W'($urandom_range(1, 99) * 100);
         default: y = YEAR_W'($urandom_range(1, 9999));
      endcase
      m = MON_W'($urandom_range(1, 12));
      d = DAY_W'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 28) : $urandom_range(29, 31));
      // noise: raw bit patterns, mostly invalid dates
      if ($urandom_range(0, 15) == 0) begin
         y = YEAR_W'($urandom);
         m = MON_W'($urandom);
         d = DAY_W'($urandom);
      end
      send_request(op, cnt, y, m, d);
   endtask

   initial begin
      int sent;
      int burst;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // distance to itself right after reset
      send_request(OP_DIST, 16'h1234, RESET_YEAR, JAN, FIRST_DAY);
      // upper limit: zero step, clamp, full distance
      send_request(OP_LOAD, 16'hFFFF, MAX_YEAR, DEC, DAYS_LONG);
      send_request(OP_ADVANCE, 16'd0, 14'h3FFF, 4'hF, 5'h1F);
      send_request(OP_ADVANCE, 16'd1, 14'd0, 4'd0, 5'd0);
      send_request(OP_DIST, 16'hFFFF, MIN_YEAR, JAN, FIRST_DAY);
      // lower limit
      send_request(OP_LOAD, 16'd0, MIN_YEAR, JAN, FIRST_DAY);
      send_request(OP_BACK, 16'd1, 14'd5, 4'd5, 5'd5);
      send_request(OP_BACK, 16'd0, 14'h3FFF, 4'hF, 5'h1F);
      send_request(OP_DIST, 16'd7, MAX_YEAR, DEC, DAYS_LONG);
      // rejected loads keep the date
      send_request(OP_LOAD, 16'd0, 14'd2023, FEB, DAYS_FEB_LEAP);
      send_request(OP_LOAD, 16'd0, 14'd0, JAN, FIRST_DAY);
      send_request(OP_LOAD, 16'd0, 14'h3FFF, 4'hF, 5'h1F);
      send_request(OP_LOAD, 16'd0, 14'd2000, 4'd0, FIRST_DAY);
      send_request(OP_LOAD, 16'd0, 14'd2000, 4'd4, 5'd0);
      send_request(OP_LOAD, 16'd0, 14'd2000, 4'd4, DAYS_LONG);
      send_request(OP_LOAD, 16'd0, 14'd1900, FEB, DAYS_FEB_LEAP);
      // leap days: 400-year rule and plain
      send_request(OP_LOAD, 16'd0, 14'd2000, FEB, DAYS_FEB_LEAP);
      send_request(OP_LOAD, 16'd0, 14'd2024, FEB, DAYS_FEB_LEAP);
      send_request(OP_ADVANCE, 16'hFFFF, 14'd1, 4'd1, 5'd1);
      send_request(OP_BACK, 16'hFFFF, 14'd1, 4'd1, 5'd1);
      send_request(OP_DIST, 16'd0, 14'd2100, FEB, DAYS_FEB_LEAP);
      // reaching a limit exactly is not a clamp
      send_request(OP_LOAD, 16'd0, MAX_YEAR, DEC, FIRST_DAY);
      send_request(OP_ADVANCE, 16'd30, 14'd0, 4'd0, 5'd0);
      send_request(OP_LOAD, 16'd0, MIN_YEAR, JAN, DAYS_LONG);
      send_request(OP_BACK, 16'd30, 14'd0, 4'd0, 5'd0);
      pause_sender(3);

      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            send_random_request();
            sent++;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
         pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30));
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests: %0d load, %0d advance, %0d back, %0d distance",
               op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
               op_tally[OP_LOAD], op_tally[OP_ADVANCE], op_tally[OP_BACK], op_tally[OP_DIST]);
      $display("%0d responses checked, %0d clamped at a calendar limit, %0d invalid dates",
               responses_checked, saturations, rejections);
      if (outstanding != 0)
         $display("%0t: %0d expected responses never arrived", $time, outstanding);
      if (error_count == 0 && outstanding == 0) begin
         $display("PASS gregorian_date_stepper");
      end else begin
         $display("FAIL gregorian_date_stepper");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/gds_pkg.sv
rtl/gds_ctrl.sv
rtl/gds_dpath.sv
rtl/gregorian_date_stepper.sv
rtl/gds_checker.sv
tb/date_result_checker.sv
tb/testbench.sv
